### rtl/core/lcc_pkg.sv
// Shared types, constants and helper functions of the Luhn card number check.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lcc_pkg;

   // payload widths
   localparam int CARD_WIDTH  = 54;
   localparam int COUNT_WIDTH = 5;
   localparam int SUM_WIDTH   = 8;
   localparam int DIGIT_WIDTH = 4;
   localparam int MOD_WIDTH   = 4;

   // binary to BCD conversion: 3 input bits per cycle, 18 BCD digits
   localparam int BITS_PER_STEP = 3;
   localparam int CONV_STEPS    = CARD_WIDTH / BITS_PER_STEP;
   localparam int BCD_DIGITS    = 18;
   localparam int BCD_WIDTH     = BCD_DIGITS * DIGIT_WIDTH;

   // digit scan: one pair of digits (plain, doubled) per cycle
   localparam int SCAN_STEPS       = BCD_DIGITS / 2;
   localparam int SCAN_INDEX_WIDTH = $clog2(SCAN_STEPS);
   localparam int STEP_CNT_WIDTH   = $clog2(CONV_STEPS);

   localparam int MAX_DIGITS     = 16;
   localparam int DECIMAL_BASE   = 10;
   localparam int VISA_LEAD      = 4;
   localparam int VISA_LEN_SHORT = 13;
   localparam int VISA_LEN_LONG  = 16;

   // controller to datapath commands
   typedef struct packed {
      logic                        load;
      logic                        conv_step;
      logic                        scan_step;
      logic [SCAN_INDEX_WIDTH-1:0] scan_index;
      logic                        capture;
   } lcc_cmd_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] digit_count;
      logic [SUM_WIDTH-1:0]   luhn_sum;
      logic                   luhn_valid;
      logic                   is_visa;
   } lcc_rsp_type;

   // doubled digit folded to a single digit (2d, minus 9 when above 9)
   function automatic logic [DIGIT_WIDTH-1:0] luhn_double(input logic [DIGIT_WIDTH-1:0] d);
      logic [DIGIT_WIDTH:0] p;
      p = {d, 1'b0};
      if (p > (DIGIT_WIDTH+1)'(DECIMAL_BASE - 1)) begin
         p = p - (DIGIT_WIDTH+1)'(DECIMAL_BASE - 1);
      end
      return p[DIGIT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/core/lcc_req_if.sv
// Request channel of the Luhn card number check: valid/ready plus card number.
// Depends on lcc_pkg for the payload width.
`default_nettype none

interface lcc_req_if import lcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CARD_WIDTH-1:0] card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

`default_nettype wire

### rtl/core/lcc_rsp_if.sv
// Response channel of the Luhn card number check: valid/ready plus result fields.
// Depends on lcc_pkg for the payload widths.
`default_nettype none

interface lcc_rsp_if import lcc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] digit_count;
   logic [SUM_WIDTH-1:0]   luhn_sum;
   logic                   luhn_valid;
   logic                   is_visa;

   modport source (output valid, output digit_count, output luhn_sum,
                   output luhn_valid, output is_visa, input ready);
   modport sink   (input valid, input digit_count, input luhn_sum,
                   input luhn_valid, input is_visa, output ready);
endinterface

`default_nettype wire

### rtl/core/lcc_ctrl.sv
// Controller of the Luhn card number check: sequences load, conversion, scan
// and response capture. Depends on lcc_pkg for the command struct and step counts.
`default_nettype none

module lcc_ctrl import lcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output lcc_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CONV   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } lcc_state_type;

   lcc_state_type             state_ff, state_in;
   logic [STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd.load      = 1'b0;
      cmd.conv_step = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.capture   = 1'b0;
      cmd.scan_index = cnt_ff[SCAN_INDEX_WIDTH-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (cnt_ff == STEP_CNT_WIDTH'(CONV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + STEP_CNT_WIDTH'(1);
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (cnt_ff == STEP_CNT_WIDTH'(SCAN_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + STEP_CNT_WIDTH'(1);
            end
         end
         ST_FINISH: begin
            // wait for the response register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/lcc_datapath.sv
// Datapath of the Luhn card number check: shift-add-3 BCD conversion, digit
// pair scan with running sums, and the response register. Depends on lcc_pkg.
`default_nettype none

module lcc_datapath import lcc_pkg::*; (
   input  logic                  clock,
   input  lcc_cmd_type           cmd,
   input  logic [CARD_WIDTH-1:0] card_number,
   output lcc_rsp_type           rsp
);

   logic [CARD_WIDTH-1:0]  bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [MOD_WIDTH-1:0]   mod_ff, mod_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DIGIT_WIDTH-1:0] lead_ff, lead_in;
   lcc_rsp_type            rsp_ff, rsp_in;

   logic [BCD_WIDTH-1:0]   bcd_conv;
   logic [CARD_WIDTH-1:0]  bin_conv;
   logic [DIGIT_WIDTH-1:0] d_plain, d_dbl;
   logic [DIGIT_WIDTH:0]   pair_sum;
   logic [DIGIT_WIDTH:0]   mod_sum;
   logic [COUNT_WIDTH-1:0] pos;
   logic                   sum_ok;

   // three shift-add-3 steps per cycle
   always_comb begin
      bcd_conv = bcd_ff;
      bin_conv = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int k = 0; k < BCD_DIGITS; k++) begin
            if (bcd_conv[k*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_WIDTH'(5)) begin
               bcd_conv[k*DIGIT_WIDTH +: DIGIT_WIDTH] =
                  bcd_conv[k*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_WIDTH'(3);
            end
         end
         bcd_conv = {bcd_conv[BCD_WIDTH-2:0], bin_conv[CARD_WIDTH-1]};
         bin_conv = {bin_conv[CARD_WIDTH-2:0], 1'b0};
      end
   end

   // low digit of the pair sits at an odd position and is added plain
   assign d_plain  = bcd_ff[DIGIT_WIDTH-1:0];
   assign d_dbl    = luhn_double(bcd_ff[2*DIGIT_WIDTH-1:DIGIT_WIDTH]);
   assign pair_sum = (DIGIT_WIDTH+1)'(d_plain) + (DIGIT_WIDTH+1)'(d_dbl);
   assign mod_sum  = (DIGIT_WIDTH+1)'(mod_ff) + pair_sum;
   assign pos      = {cmd.scan_index, 1'b0};

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      sum_in   = sum_ff;
      mod_in   = mod_ff;
      count_in = count_ff;
      lead_in  = lead_ff;
      if (cmd.load) begin
         bin_in   = card_number;
         bcd_in   = '0;
         sum_in   = '0;
         mod_in   = '0;
         count_in = COUNT_WIDTH'(1);
         lead_in  = '0;
      end else if (cmd.conv_step) begin
         bin_in = bin_conv;
         bcd_in = bcd_conv;
      end else if (cmd.scan_step) begin
         bcd_in = {(2*DIGIT_WIDTH)'(0), bcd_ff[BCD_WIDTH-1:2*DIGIT_WIDTH]};
         sum_in = sum_ff + SUM_WIDTH'(pair_sum);
         // running remainder mod 10; input stays below 28
         if (mod_sum >= (DIGIT_WIDTH+1)'(2*DECIMAL_BASE)) begin
            mod_in = MOD_WIDTH'(mod_sum - (DIGIT_WIDTH+1)'(2*DECIMAL_BASE));
         end else if (mod_sum >= (DIGIT_WIDTH+1)'(DECIMAL_BASE)) begin
            mod_in = MOD_WIDTH'(mod_sum - (DIGIT_WIDTH+1)'(DECIMAL_BASE));
         end else begin
            mod_in = MOD_WIDTH'(mod_sum);
         end
         // highest nonzero digit so far sets length and leading digit
         if (bcd_ff[2*DIGIT_WIDTH-1:DIGIT_WIDTH] != '0) begin
            count_in = pos + COUNT_WIDTH'(2);
            lead_in  = bcd_ff[2*DIGIT_WIDTH-1:DIGIT_WIDTH];
         end else if (d_plain != '0) begin
            count_in = pos + COUNT_WIDTH'(1);
            lead_in  = d_plain;
         end
      end
   end

   assign sum_ok = (mod_ff == '0) && (count_ff <= COUNT_WIDTH'(MAX_DIGITS));

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.capture) begin
         rsp_in.digit_count = count_ff;
         rsp_in.luhn_sum    = sum_ff;
         rsp_in.luhn_valid  = sum_ok;
         rsp_in.is_visa     = sum_ok && (lead_ff == DIGIT_WIDTH'(VISA_LEAD)) &&
                              ((count_ff == COUNT_WIDTH'(VISA_LEN_SHORT)) ||
                               (count_ff == COUNT_WIDTH'(VISA_LEN_LONG)));
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      sum_ff   <= sum_in;
      mod_ff   <= mod_in;
      count_ff <= count_in;
      lead_ff  <= lead_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/luhn_card_number_check.sv
// Luhn mod-10 card number check, top level: controller plus datapath.
// An accepted request is converted, scanned, then captured into the response register;
// binary to BCD conversion (3 bits per cycle) and digit scan (2 digits per cycle)
// set its time, and capture waits while the response register is still full.
// A new request is taken only once the previous one is captured, even while its response still waits on rsp_bus.
// Reset (synchronous, active high) clears the controller and response valid.
`default_nettype none

module luhn_card_number_check import lcc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lcc_req_if.sink  req_bus,
   lcc_rsp_if.source rsp_bus
);

   lcc_cmd_type cmd;
   lcc_rsp_type rsp_data;

   // Sequencer: IDLE takes a request, CONV runs the shift-add-3 conversion,
   // SCAN walks digit pairs from the least significant end, FINISH loads
   // the response register once it is free.
   lcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   // Datapath: BCD conversion register, running Luhn sum, remainder mod 10,
   // digit count and leading digit, plus the response register.
   lcc_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .card_number (req_bus.card_number),
      .rsp         (rsp_data)
   );

   assign rsp_bus.digit_count = rsp_data.digit_count;
   assign rsp_bus.luhn_sum    = rsp_data.luhn_sum;
   assign rsp_bus.luhn_valid  = rsp_data.luhn_valid;
   assign rsp_bus.is_visa     = rsp_data.is_visa;

endmodule

`default_nettype wire
